/* src/kslr_pkg.sv */
// ----------------------------------------------------------------------------
// kslr_pkg: shared definitions for the keystream LZSS ring decompressor
// Ring geometry, keystream constants, configuration register indexes and the
// ring write port bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kslr_pkg;

    // History ring geometry.
    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(12'hFEE);

    // Match lengths run from three to eighteen bytes.
    localparam int MIN_MATCH = 3;
    localparam int RUN_W     = 5;

    // Emitted byte counter.
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Linear congruential keystream.
    localparam logic [31:0] KEY_MUL = 32'd1103515245;
    localparam logic [31:0] KEY_ADD = 32'd12345;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_KEY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT = 2'd1;

    // Write port of the history ring.
    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [7:0]         data;
    } ring_wr_t;

endpackage

`default_nettype wire

/* src/keystream_lzss_ring_decompressor.sv */
// ----------------------------------------------------------------------------
// keystream_lzss_ring_decompressor: descrambling LZSS decoder, 4 KiB history
// Takes one scrambled compressed byte per transfer and produces the
// decompressed bytes through an output register.
// ----------------------------------------------------------------------------
// After reset the history ring is cleared, during which no input is taken
// (configuration writes are). Each accepted byte then passes through ST_KEY,
// which advances the key, and ST_DECODE, which decodes it. A flag byte, a
// literal or the first byte of a match pair ends there. The second byte of
// a pair starts the copy engine, which reads the ring once per output byte
// through its single read port and waits while the output side is stalled;
// a match copies 3 to 18 bytes. Write initial_key (index 0) to seed the key
// and output_limit (index 1) before streaming.
`default_nettype none

module keystream_lzss_ring_decompressor (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kslr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data,
    // Compressed input channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_final_byte,
    // Decompressed output channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [7:0]                       m_out_byte,
    output logic                                  m_run_last,
    output logic                                  m_finished
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_KEY    = 4'b0010,
        ST_DECODE = 4'b0100,
        ST_COPY   = 4'b1000
    } state_t;

    state_t                           st_reg, st_next;
    logic [kslr_pkg::COUNT_W-1:0]     limit_reg;
    logic [kslr_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             done_reg, done_next;
    logic [7:0]                       byte_reg, byte_next;
    logic                             last_reg, last_next;
    logic [7:0]                       flag_bits_reg, flag_bits_next;
    logic [3:0]                       flag_index_reg, flag_index_next;
    logic                             pending_reg, pending_next;
    logic [7:0]                       low_reg, low_next;
    logic [kslr_pkg::RING_AW-1:0]     wpos_reg, wpos_next;
    logic [kslr_pkg::RING_AW-1:0]     src_reg, src_next;
    logic [kslr_pkg::RUN_W-1:0]       issue_left_reg, issue_left_next;
    logic [kslr_pkg::RUN_W-1:0]       emit_left_reg, emit_left_next;
    logic                             rd_valid_reg, rd_valid_next;
    logic                             byp_hit_reg, byp_hit_next;
    logic [7:0]                       byp_data_reg, byp_data_next;
    logic                             fin_reg, fin_next;
    logic                             m_valid_reg, m_valid_next;
    logic [7:0]                       out_byte_reg, out_byte_next;
    logic                             run_last_reg, run_last_next;
    logic                             finished_reg, finished_next;

    logic                             clearing;
    logic                             cfg_fire;
    logic                             s_fire;
    logic                             out_free;
    logic                             consume;
    logic                             issue;
    logic [7:0]                       plain;
    logic [7:0]                       copy_data;
    logic [kslr_pkg::RUN_W-1:0]       amount;
    logic [kslr_pkg::COUNT_W:0]       pair_sum;
    logic [kslr_pkg::COUNT_W-1:0]     pair_cnt;
    logic [kslr_pkg::COUNT_W-1:0]     lit_cnt;
    logic [7:0]                       rd_data;
    kslr_pkg::ring_wr_t               ring_wr;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_ready   = (st_reg == ST_IDLE) & ~clearing;
    assign s_fire    = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;

    // Output limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_fire && cfg_index == kslr_pkg::CFG_OUTPUT_LIMIT) begin
            limit_reg <= cfg_data[kslr_pkg::COUNT_W-1:0];
        end
    end

    kslr_keystream u_keystream (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (cfg_fire && cfg_index == kslr_pkg::CFG_INITIAL_KEY),
        .load_key (cfg_data),
        .advance  (st_reg == ST_KEY),
        .data_in  (byte_reg),
        .data_out (plain)
    );

    kslr_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (ring_wr),
        .rd_en    (issue),
        .rd_addr  (src_reg),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    // Copy engine handshake between ring reads and the output register.
    assign consume   = (st_reg == ST_COPY) & rd_valid_reg & out_free;
    assign issue     = (st_reg == ST_COPY) & (issue_left_reg != '0)
                       & (~rd_valid_reg | consume);
    assign copy_data = byp_hit_reg ? byp_data_reg : rd_data;

    // Match length and saturating counts after a literal or a match.
    assign amount   = {1'b0, plain[3:0]} + kslr_pkg::RUN_W'(kslr_pkg::MIN_MATCH);
    assign pair_sum = {1'b0, count_reg}
                      + {{(kslr_pkg::COUNT_W + 1 - kslr_pkg::RUN_W){1'b0}}, amount};
    assign pair_cnt = pair_sum[kslr_pkg::COUNT_W] ? kslr_pkg::COUNT_MAX
                                                  : pair_sum[kslr_pkg::COUNT_W-1:0];
    assign lit_cnt  = (count_reg == kslr_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Sequencer.
    always_comb begin
        st_next         = st_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        pending_next    = pending_reg;
        low_next        = low_reg;
        wpos_next       = wpos_reg;
        src_next        = src_reg;
        issue_left_next = issue_left_reg;
        emit_left_next  = emit_left_reg;
        rd_valid_next   = rd_valid_reg;
        byp_hit_next    = byp_hit_reg;
        byp_data_next   = byp_data_reg;
        fin_next        = fin_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        finished_next   = finished_reg;
        ring_wr.en      = 1'b0;
        ring_wr.addr    = wpos_reg;
        ring_wr.data    = plain;

        case (st_reg)
            ST_IDLE: begin
                if (s_fire && !done_reg) begin
                    if (count_reg >= limit_reg) begin
                        done_next = 1'b1;
                    end else begin
                        byte_next = s_data_byte;
                        last_next = s_final_byte;
                        st_next   = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                st_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (flag_index_reg[3]) begin
                    // Flag byte: eight items follow, low bit first.
                    flag_bits_next  = plain;
                    flag_index_next = '0;
                    done_next       = last_reg;
                    st_next         = ST_IDLE;
                end else if (flag_bits_reg[flag_index_reg[2:0]]) begin
                    // Literal byte.
                    if (out_free) begin
                        ring_wr.en      = 1'b1;
                        wpos_next       = wpos_reg + 1'b1;
                        count_next      = lit_cnt;
                        m_valid_next    = 1'b1;
                        out_byte_next   = plain;
                        run_last_next   = 1'b1;
                        finished_next   = last_reg | (lit_cnt >= limit_reg);
                        done_next       = last_reg | (lit_cnt >= limit_reg);
                        flag_index_next = flag_index_reg + 1'b1;
                        st_next         = ST_IDLE;
                    end
                end else if (!pending_reg) begin
                    // First byte of a match pair.
                    low_next     = plain;
                    pending_next = 1'b1;
                    done_next    = last_reg;
                    st_next      = ST_IDLE;
                end else begin
                    // Second byte of a pair: start the copy.
                    pending_next    = 1'b0;
                    src_next        = {plain[7:4], low_reg};
                    issue_left_next = amount;
                    emit_left_next  = amount;
                    rd_valid_next   = 1'b0;
                    count_next      = pair_cnt;
                    fin_next        = last_reg | (pair_cnt >= limit_reg);
                    flag_index_next = flag_index_reg + 1'b1;
                    st_next         = ST_COPY;
                end
            end
            ST_COPY: begin
                if (consume) begin
                    ring_wr.en     = 1'b1;
                    ring_wr.data   = copy_data;
                    wpos_next      = wpos_reg + 1'b1;
                    emit_left_next = emit_left_reg - 1'b1;
                    m_valid_next   = 1'b1;
                    out_byte_next  = copy_data;
                    run_last_next  = (emit_left_reg == kslr_pkg::RUN_W'(1));
                    finished_next  = fin_reg;
                    if (emit_left_reg == kslr_pkg::RUN_W'(1)) begin
                        done_next = fin_reg;
                        st_next   = ST_IDLE;
                    end
                end
                if (issue) begin
                    // A read that meets the byte written this cycle takes it directly.
                    src_next        = src_reg + 1'b1;
                    issue_left_next = issue_left_reg - 1'b1;
                    rd_valid_next   = 1'b1;
                    byp_hit_next    = consume & (wpos_reg == src_reg);
                    byp_data_next   = copy_data;
                end else if (consume) begin
                    rd_valid_next = 1'b0;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            flag_bits_reg  <= '0;
            flag_index_reg <= 4'd8;
            pending_reg    <= 1'b0;
            low_reg        <= '0;
            wpos_reg       <= kslr_pkg::RING_START;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            flag_bits_reg  <= flag_bits_next;
            flag_index_reg <= flag_index_next;
            pending_reg    <= pending_next;
            low_reg        <= low_next;
            wpos_reg       <= wpos_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        src_reg      <= src_next;
        byp_hit_reg  <= byp_hit_next;
        byp_data_reg <= byp_data_next;
        fin_reg      <= fin_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        finished_reg <= finished_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = run_last_reg;
    assign m_finished = finished_reg;

`ifndef ASSERT_OFF
    // Every issued but unconsumed ring read is exactly the pending read data.
    a_copy_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_COPY) |->
            (emit_left_reg - issue_left_reg == kslr_pkg::RUN_W'(rd_valid_reg)))
        else $error("copy engine read and emit counts out of step");

    // Decoding stays finished until reset.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("done flag cleared without reset");

    // A half-received pair can only exist inside a flag group.
    a_pair_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> !flag_index_reg[3])
        else $error("pair pending while a flag byte is expected");

    // No item is processed while the ring is still being cleared.
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> (st_reg == ST_IDLE) && !m_valid_reg)
        else $error("decoder active during ring clearing");
`endif

endmodule

`default_nettype wire

/* src/kslr_ring.sv */
// ----------------------------------------------------------------------------
// kslr_ring: 4 KiB history ring
// One write port and one registered read port. After reset the ring is swept
// to zero, one entry per cycle, while the clearing status is high.
// ----------------------------------------------------------------------------
`default_nettype none

module kslr_ring (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire kslr_pkg::ring_wr_t            wr,
    input  wire logic                          rd_en,
    input  wire logic [kslr_pkg::RING_AW-1:0]  rd_addr,
    output logic      [7:0]                    rd_data,
    output logic                               clearing
);

    logic [7:0]                   mem [kslr_pkg::RING_DEPTH];
    logic [7:0]                   rd_data_reg;
    logic                         clear_busy_reg;
    logic [kslr_pkg::RING_AW-1:0] clear_addr_reg;
    logic                         we;
    logic [kslr_pkg::RING_AW-1:0] waddr;
    logic [7:0]                   wdata;

    // Clearing sweep owns the write port until it finishes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == {kslr_pkg::RING_AW{1'b1}}) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    assign we    = clear_busy_reg | wr.en;
    assign waddr = clear_busy_reg ? clear_addr_reg : wr.addr;
    assign wdata = clear_busy_reg ? 8'h00 : wr.data;

    // Memory write.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_busy_reg;

endmodule

`default_nettype wire

/* src/kslr_keystream.sv */
// ----------------------------------------------------------------------------
// kslr_keystream: key register and descrambler
// Holds the 32-bit key, advances it by the linear congruential step and
// XORs the incoming byte with the mask derived from the current key.
// ----------------------------------------------------------------------------
`default_nettype none

module kslr_keystream (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load_en,
    input  wire logic [31:0] load_key,
    input  wire logic        advance,
    input  wire logic [7:0]  data_in,
    output logic      [7:0]  data_out
);

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [31:0] key_prod;
    logic [14:0] key_bits;
    logic [22:0] scaled;

    // One multiply per advance, registered into the key.
    assign key_prod = key_reg * kslr_pkg::KEY_MUL;

    always_comb begin
        key_next = key_reg;
        if (load_en) begin
            key_next = load_key;
        end else if (advance) begin
            key_next = key_prod + kslr_pkg::KEY_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    // Mask is (bits 30..16 of the key) * 255 / 32768, built as shift minus value.
    assign key_bits = key_reg[30:16];
    assign scaled   = {key_bits, 8'h00} - {8'h00, key_bits};
    assign data_out = data_in ^ scaled[22:15];

endmodule

`default_nettype wire
